/* sv/crcwp_pkg.sv */
`default_nettype none

package crcwp_pkg;

    localparam logic [7:0]  CRC_POLY          = 8'h31;
    localparam logic [7:0]  CRC_SEED          = 8'hFF;
    localparam logic [15:0] ALARM_LIMIT_RESET = 16'd800;

    // Position of the next byte within a six-byte reply
    typedef enum logic [2:0] {
        POS_W1_HI  = 3'd0,
        POS_W1_LO  = 3'd1,
        POS_W1_CRC = 3'd2,
        POS_W2_HI  = 3'd3,
        POS_W2_LO  = 3'd4,
        POS_W2_CRC = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FIRST_BAD  = 2'd1,
        STAT_SECOND_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic        alarm;
        status_t     status;
        logic [15:0] second_word;
        logic [15:0] first_word;
    } result_t;

    // One byte of CRC-8, MSB first, unrolled over the eight bit steps
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/crcwp_frame.sv */
`default_nettype none

// Input register, reply byte tracking and CRC check; one result per reply
module crcwp_frame (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_start,
    input  wire logic [15:0]       alarm_limit,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output crcwp_pkg::result_t     res
);

    logic                vld_reg;
    logic [7:0]          byte_reg;
    logic                start_reg;

    crcwp_pkg::pos_t     pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic [7:0]          high_reg, high_next;
    logic [15:0]         first_reg, first_next;
    logic                good_reg, good_next;
    logic [7:0]          low2_reg, low2_next;

    crcwp_pkg::pos_t     pos;
    logic [7:0]          crc_in;
    logic [7:0]          crc_calc;
    logic                is_last;
    logic                advance;

    assign pos      = start_reg ? crcwp_pkg::POS_W1_HI : pos_reg;
    assign crc_in   = (pos == crcwp_pkg::POS_W1_HI || pos == crcwp_pkg::POS_W2_HI)
                      ? crcwp_pkg::CRC_SEED : crc_reg;
    assign crc_calc = crcwp_pkg::crc8_step(crc_in, byte_reg);
    assign is_last  = vld_reg && (pos == crcwp_pkg::POS_W2_CRC);
    assign advance  = vld_reg && (!is_last || res_ready);
    assign in_ready = !vld_reg || advance;
    assign res_valid = is_last;

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            vld_reg <= 1'b1;
        end else if (advance) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= crcwp_pkg::POS_W1_HI;
            crc_reg   <= crcwp_pkg::CRC_SEED;
            high_reg  <= 8'd0;
            first_reg <= 16'd0;
            good_reg  <= 1'b0;
            low2_reg  <= 8'd0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            high_reg  <= high_next;
            first_reg <= first_next;
            good_reg  <= good_next;
            low2_reg  <= low2_next;
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        first_next = first_reg;
        good_next  = good_reg;
        low2_next  = low2_reg;
        res        = '0;
        res.status = crcwp_pkg::STAT_OK;

        // result payload, only taken when is_last
        if (!good_reg) begin
            res.status = crcwp_pkg::STAT_FIRST_BAD;
        end else if (crc_reg != byte_reg) begin
            res.status = crcwp_pkg::STAT_SECOND_BAD;
        end else begin
            res.first_word  = first_reg;
            res.second_word = {high_reg, low2_reg};
            res.alarm       = first_reg > alarm_limit;
        end

        if (advance) begin
            unique case (pos)
                crcwp_pkg::POS_W1_HI: begin
                    crc_next  = crc_calc;
                    high_next = byte_reg;
                    pos_next  = crcwp_pkg::POS_W1_LO;
                end
                crcwp_pkg::POS_W1_LO: begin
                    crc_next   = crc_calc;
                    first_next = {high_reg, byte_reg};
                    pos_next   = crcwp_pkg::POS_W1_CRC;
                end
                crcwp_pkg::POS_W1_CRC: begin
                    good_next = (crc_reg == byte_reg);
                    crc_next  = crcwp_pkg::CRC_SEED;
                    pos_next  = crcwp_pkg::POS_W2_HI;
                end
                crcwp_pkg::POS_W2_HI: begin
                    crc_next  = crc_calc;
                    high_next = byte_reg;
                    pos_next  = crcwp_pkg::POS_W2_LO;
                end
                crcwp_pkg::POS_W2_LO: begin
                    crc_next  = crc_calc;
                    low2_next = byte_reg;
                    pos_next  = crcwp_pkg::POS_W2_CRC;
                end
                default: begin
                    crc_next = crcwp_pkg::CRC_SEED;
                    pos_next = crcwp_pkg::POS_W1_HI;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != crcwp_pkg::STAT_OK
        |-> res.first_word == 16'd0 && res.second_word == 16'd0 && !res.alarm)
        else $error("words not zeroed on CRC error");

    a_stall_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> is_last && !res_ready)
        else $error("input stalled without a blocked result");

    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_last |=> pos_reg == crcwp_pkg::POS_W1_HI)
        else $error("position did not wrap after last byte");

    a_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pos == crcwp_pkg::POS_W1_HI |=> pos_reg == crcwp_pkg::POS_W1_LO)
        else $error("position did not step after first byte");
`endif

endmodule

`default_nettype wire

/* sv/crcwp_skid.sv */
`default_nettype none

// Result register with one skid entry; ready does not depend on m_tready
module crcwp_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  crcwp_pkg::result_t     in_res,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output crcwp_pkg::result_t     out_res
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    crcwp_pkg::result_t  main_reg;
    crcwp_pkg::result_t  skid_reg;
    logic                push;
    logic                pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : in_res;
        end else if (push) begin
            skid_reg <= in_res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while main register empty");
`endif

endmodule

`default_nettype wire

/* sv/crc_checked_word_pair_receiver.sv */
`default_nettype none

// CRC-checked word pair receiver.
// Input stream (s_): one reply byte per word, s_tdata[7:0] = rx_byte,
// s_tuser = frame_start (byte is the first of a new reply; an open reply
// is dropped without a result). Without a start mark bytes keep counting
// and the count wraps after six, so back-to-back replies need no mark.
// A reply is: word 1 high, low, CRC-8; word 2 high, low, CRC-8
// (poly 0x31, seed 0xFF, MSB first, over each word's two bytes).
// Output stream (m_): one word per reply, given on its sixth byte.
// Path: the sixth byte lands in the input register at its handshake; once
// the skid buffer has room the result moves into the result register (or
// the skid entry while that register is held), which drives m_tvalid.
// Throughput: one byte per cycle unless a result is held (combinational CRC).
// Stalls: a held m_tready is absorbed by a one-entry skid buffer; s_tready
// drops only when a finished result cannot enter it.
// Reset (aresetn low, synchronous): byte count to reply start, CRC to 0xFF,
// output empty, alarm limit back to 800. cfg_wr_en writes the limit; write
// it only while idle.
module crc_checked_word_pair_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] first_word, [31:16] second_word
    output logic [2:0]       m_tuser,   // [1:0] status, [2] alarm
    // alarm limit register
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    logic [15:0]         limit_reg;
    logic                res_valid;
    logic                res_ready;
    crcwp_pkg::result_t  res;
    crcwp_pkg::result_t  out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= crcwp_pkg::ALARM_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    crcwp_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_start    (s_tuser),
        .alarm_limit (limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    crcwp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.second_word, out_res.first_word};
    assign m_tuser = {out_res.alarm, out_res.status};

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    // one planned input word: reply byte, start mark, and an optional hand-written reading
    typedef struct {
        logic [7:0]          data;
        logic                start;
        logic                pinned;
        crcwp_pkg::result_t  want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;   // [7:0] rx_byte
    logic        s_tuser     = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;               // [15:0] first_word, [31:16] second_word
    logic [2:0]  m_tuser;               // [1:0] status, [2] alarm
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    crc_checked_word_pair_receiver uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Decoder state mirrored on the testbench side
    // ------------------------------------------------------------------
    crcwp_pkg::pos_t  reply_pos;
    logic [7:0]       word_crc;
    logic [7:0]       hi_byte;
    logic [15:0]      first_word_seen;
    logic             first_crc_ok;
    logic [7:0]       second_lo_byte;
    logic [15:0]      alarm_limit;

    crcwp_pkg::result_t  expected_readings[$];   // readings still owed by the block
    stim_row_t           byte_plan[$];           // words waiting to be offered
    int          bytes_sent  = 0;
    int          mismatches  = 0;
    logic        quiet       = 1'b0;     // both sides run with no gaps while set

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Bitwise form of the CRC-8 (poly 0x31, MSB first): feed one data bit per shift
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? crcwp_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advance the mirrored decoder by one accepted byte; returns 1 when a reading is due
    function automatic logic decode_reply_byte(input logic [7:0] b, input logic start,
                                               output crcwp_pkg::result_t reading);
        crcwp_pkg::pos_t pos;
        logic due;
        pos     = start ? crcwp_pkg::POS_W1_HI : reply_pos;
        due     = 1'b0;
        reading = '0;
        case (pos)
            crcwp_pkg::POS_W1_HI: begin
                word_crc = crc8_update(crcwp_pkg::CRC_SEED, b);
                hi_byte  = b;
            end
            crcwp_pkg::POS_W1_LO: begin
                word_crc        = crc8_update(word_crc, b);
                first_word_seen = {hi_byte, b};
            end
            crcwp_pkg::POS_W1_CRC: begin
                first_crc_ok = (word_crc == b);
                word_crc     = crcwp_pkg::CRC_SEED;
            end
            crcwp_pkg::POS_W2_HI: begin
                // second word CRC starts over from the seed
                word_crc = crc8_update(crcwp_pkg::CRC_SEED, b);
                hi_byte  = b;
            end
            crcwp_pkg::POS_W2_LO: begin
                word_crc       = crc8_update(word_crc, b);
                second_lo_byte = b;
            end
            default: begin
                due = 1'b1;
                if (!first_crc_ok) begin
                    // second CRC not looked at
                    reading.status = crcwp_pkg::STAT_FIRST_BAD;
                end else if (word_crc != b) begin
                    reading.status = crcwp_pkg::STAT_SECOND_BAD;
                end else begin
                    reading.status      = crcwp_pkg::STAT_OK;
                    reading.first_word  = first_word_seen;
                    reading.second_word = {hi_byte, second_lo_byte};
                    reading.alarm       = first_word_seen > alarm_limit;
                end
                word_crc = crcwp_pkg::CRC_SEED;
            end
        endcase
        reply_pos = (pos == crcwp_pkg::POS_W2_CRC) ? crcwp_pkg::POS_W1_HI
                                                   : crcwp_pkg::pos_t'(pos + 3'd1);
        return due;
    endfunction

    task automatic push_row(input logic [7:0] data, input logic start,
                            input logic pinned, input crcwp_pkg::result_t want);
        stim_row_t row;
        row.data   = data;
        row.start  = start;
        row.pinned = pinned;
        row.want   = want;
        byte_plan.push_back(row);
    endtask

    // Six bytes of a reply; a bad CRC byte is the right one with some bits flipped.
    // A pinned reading, if given, goes with the last byte.
    task automatic push_reply(input logic [15:0] w1, input logic [15:0] w2, input logic start,
                              input logic bad1, input logic bad2,
                              input logic pinned, input crcwp_pkg::result_t want);
        logic [7:0] c1;
        logic [7:0] c2;
        c1 = crc8_update(crc8_update(crcwp_pkg::CRC_SEED, w1[15:8]), w1[7:0]);
        c2 = crc8_update(crc8_update(crcwp_pkg::CRC_SEED, w2[15:8]), w2[7:0]);
        if (bad1) c1 = c1 ^ 8'($urandom_range(1, 255));
        if (bad2) c2 = c2 ^ 8'($urandom_range(1, 255));
        push_row(w1[15:8], start, 1'b0, '0);
        push_row(w1[7:0], 1'b0, 1'b0, '0);
        push_row(c1, 1'b0, 1'b0, '0);
        push_row(w2[15:8], 1'b0, 1'b0, '0);
        push_row(w2[7:0], 1'b0, 1'b0, '0);
        push_row(c2, 1'b0, pinned, want);
    endtask

    // Offer one word after a random gap, wait for the handshake, then predict
    task automatic send_byte(input stim_row_t row);
        int                  gap;
        crcwp_pkg::result_t  reading;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        s_tuser  <= row.start;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (decode_reply_byte(row.data, row.start, reading)) begin
            expected_readings.push_back(row.pinned ? row.want : reading);
        end
    endtask

    task automatic play_plan();
        while (byte_plan.size() != 0) begin
            send_byte(byte_plan.pop_front());
        end
    endtask

    // Drain everything, let the pipeline empty, then write the limit
    task automatic set_alarm_limit(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        alarm_limit = value;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected %h, got %h", name, want, seen);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] phase_limits[5];
        logic [15:0] w1;
        int          phase_end;
        int          pick;
        int          fault;
        logic        resync;

        reply_pos       = crcwp_pkg::POS_W1_HI;
        word_crc        = crcwp_pkg::CRC_SEED;
        hi_byte         = 8'h00;
        first_word_seen = 16'h0000;
        first_crc_ok    = 1'b0;
        second_lo_byte  = 8'h00;
        alarm_limit     = crcwp_pkg::ALARM_LIMIT_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, limit still at its reset value of 800.
        // Extreme words with good CRCs, marked start.
        push_reply(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        // Back to back, no start mark; 0xFFFF is above the limit -> alarm
        push_reply(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        // Reply cut short by a new start mark: no reading for the dropped bytes
        push_row(8'h12, 1'b1, 1'b0, '0);
        push_row(8'h34, 1'b0, 1'b0, '0);
        // First CRC bad: words forced to zero, no alarm
        push_reply(16'hBEEF, 16'h1234, 1'b1, 1'b1, 1'b0, 1'b1,
                   '{alarm: 1'b0, status: crcwp_pkg::STAT_FIRST_BAD,
                     second_word: 16'h0000, first_word: 16'h0000});
        // Only the second CRC bad, first word right at the limit
        push_reply(16'd800, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1,
                   '{alarm: 1'b0, status: crcwp_pkg::STAT_SECOND_BAD,
                     second_word: 16'h0000, first_word: 16'h0000});
        play_plan();

        // Random phases, one limit setting each, extremes first
        phase_limits[0] = 16'h0000;
        phase_limits[1] = 16'hFFFF;
        phase_limits[2] = 16'($urandom_range(0, 65535));
        phase_limits[3] = 16'($urandom_range(0, 2047));
        phase_limits[4] = 16'd801;
        phase_end = bytes_sent;
        resync    = 1'b1;
        foreach (phase_limits[p]) begin
            set_alarm_limit(phase_limits[p]);
            resync    = 1'b1;
            phase_end = phase_end + 255;
            while (bytes_sent < phase_end) begin
                // every fifth stretch of ~90 words runs with no gaps on either side
                quiet = ((bytes_sent / 90) % 5) == 2;
                pick  = $urandom_range(0, 9);
                if (pick < 7) begin
                    // full-length reply, sometimes with a bad CRC; first word often sits on the alarm boundary
                    case ($urandom_range(0, 5))
                        0:       w1 = alarm_limit;
                        1:       w1 = alarm_limit + 16'd1;
                        2:       w1 = alarm_limit - 16'd1;
                        default: w1 = 16'($urandom_range(0, 65535));
                    endcase
                    fault = $urandom_range(0, 9);
                    push_reply(w1, 16'($urandom_range(0, 65535)),
                               resync | 1'($urandom_range(0, 1)),
                               fault == 0, fault == 1, 1'b0, '0);
                    resync = 1'b0;
                end else if (pick == 7) begin
                    // truncated reply
                    push_row(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                    repeat ($urandom_range(0, 4))
                        push_row(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                    resync = 1'b1;
                end else begin
                    // loose bytes with random start marks
                    repeat ($urandom_range(1, 4))
                        push_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'b0, '0);
                    resync = 1'b1;
                end
                play_plan();
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus two long hold-offs that back the block up
    // ------------------------------------------------------------------
    initial begin
        int taken;
        int hold;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken == 30 || taken == 120) begin
                hold = 300;   // sender keeps going, block must stall s_tready
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Compare each accepted reading against the oldest one owed
    always @(posedge aclk) begin : check_reading
        crcwp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: tdata %h tuser %h", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                check_field("first_word", want.first_word, m_tdata[15:0]);
                check_field("second_word", want.second_word, m_tdata[31:16]);
                check_field("status", 16'(want.status), 16'(m_tuser[1:0]));
                check_field("alarm", 16'(want.alarm), 16'(m_tuser[2]));
            end
        end
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
